### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during rst.
`define LSH_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during rst.
`define LSH_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

### rtl/lsh_pkg.sv
// Types and constants for the 3x3 Laplacian sharpening block.
package lsh_pkg;

  localparam int PIX_W       = 8;
  localparam int POS_W       = 10;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = 12;
  localparam int QUOT_W      = 11;

  localparam int MAX_HEIGHT      = 1024;
  localparam int FRAME_MIN       = 3;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Divide by 3 for magnitudes up to 2040: floor(m * 683 / 2048) is exact
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int MAG_W      = 11;
  localparam int PROD_W     = 21;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // One new window column: two rows above, row above, current row
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } lsh_col_t;

  // Result bookkeeping for one accepted pixel
  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             done;
  } lsh_meta_t;

endpackage

### rtl/lsh_ifs.sv
// Valid/ready channel interfaces: pixel input, result output, configuration writes.
interface lsh_pix_if;
  logic                      valid;
  logic                      ready;
  logic [lsh_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lsh_res_if;
  logic                      valid;
  logic                      ready;
  logic [lsh_pkg::PIX_W-1:0] sharpened;
  logic [lsh_pkg::POS_W-1:0] out_row;
  logic [lsh_pkg::POS_W-1:0] out_col;
  logic                      frame_done;

  modport source (output valid, output sharpened, output out_row, output out_col,
                  output frame_done, input ready);
  modport sink   (input valid, input sharpened, input out_row, input out_col,
                  input frame_done, output ready);
endinterface

interface lsh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lsh_pkg::CFG_IDX_W-1:0]  index;
  logic [lsh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/lsh_sharpen.sv
// 3x3 window and sharpening pipeline: kernel sum, divide by 3, add centre and clamp.
module lsh_sharpen (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lsh_pkg::lsh_col_t column,
  input  lsh_pkg::lsh_meta_t meta,
  output logic              load_ready,
  lsh_res_if.source         res
);

  logic [lsh_pkg::PIX_W-1:0] win [9];
  logic [lsh_pkg::PIX_W-1:0] win_next [9];
  logic [lsh_pkg::MAG_W-1:0] nbr_sum;
  logic signed [lsh_pkg::SUM_W-1:0] sum_next;

  logic                             s2_v;
  logic signed [lsh_pkg::SUM_W-1:0] s2_sum;
  logic [lsh_pkg::PIX_W-1:0]        s2_centre;
  lsh_pkg::lsh_meta_t               s2_meta;

  logic                              s3_v;
  logic signed [lsh_pkg::QUOT_W-1:0] s3_quot;
  logic [lsh_pkg::PIX_W-1:0]         s3_centre;
  lsh_pkg::lsh_meta_t                s3_meta;

  logic                               o_v;
  logic [lsh_pkg::PIX_W-1:0]          o_pix;
  lsh_pkg::lsh_meta_t                 o_meta;

  logic rdy_o;
  logic rdy3;
  logic rdy2;

  logic [lsh_pkg::MAG_W-1:0]          mag;
  logic [lsh_pkg::PROD_W-1:0]         prod;
  logic [lsh_pkg::QUOT_W-2:0]         qmag;
  logic signed [lsh_pkg::QUOT_W-1:0]  quot_next;
  logic signed [lsh_pkg::SUM_W-1:0]   val;
  logic [lsh_pkg::PIX_W-1:0]          pix_next;

  assign rdy_o      = !o_v || res.ready;
  assign rdy3       = !s3_v || rdy_o;
  assign rdy2       = !s2_v || rdy3;
  assign load_ready = rdy2;

  // Shift the window one column left and bring in the new column on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k*3]   = win[k*3+1];
      win_next[k*3+1] = win[k*3+2];
    end
    win_next[2] = column.top;
    win_next[5] = column.mid;
    win_next[8] = column.bot;
  end

  always_comb begin
    nbr_sum = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        nbr_sum = nbr_sum + lsh_pkg::MAG_W'(win_next[k]);
      end
    end
    sum_next = $signed(lsh_pkg::SUM_W'({win_next[4], 3'b000}))
             - $signed({1'b0, nbr_sum});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win <= win_next;
    end
  end

  // Stage 2: kernel sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (load) begin
      s2_v <= meta.emit;
    end else if (rdy3) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_sum    <= sum_next;
      s2_centre <= win_next[4];
      s2_meta   <= meta;
    end
  end

  // Divide magnitude by 3 through a reciprocal multiply, then restore the sign
  always_comb begin
    mag       = s2_sum[lsh_pkg::SUM_W-1] ? lsh_pkg::MAG_W'(-s2_sum)
                                         : lsh_pkg::MAG_W'(s2_sum);
    prod      = lsh_pkg::PROD_W'(mag) * lsh_pkg::PROD_W'(lsh_pkg::DIV3_MUL);
    qmag      = prod[lsh_pkg::PROD_W-1:lsh_pkg::DIV3_SHIFT];
    quot_next = s2_sum[lsh_pkg::SUM_W-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  // Stage 3: quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (rdy3) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v) begin
      s3_quot   <= quot_next;
      s3_centre <= s2_centre;
      s3_meta   <= s2_meta;
    end
  end

  // Add centre back and clamp to pixel range
  always_comb begin
    val = lsh_pkg::SUM_W'(s3_quot) + $signed({4'b0000, s3_centre});
    if (val < 0) begin
      pix_next = '0;
    end else if (val > $signed(lsh_pkg::SUM_W'(lsh_pkg::PIX_MAX))) begin
      pix_next = lsh_pkg::PIX_MAX;
    end else begin
      pix_next = val[lsh_pkg::PIX_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (rdy_o) begin
      o_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && s3_v) begin
      o_pix  <= pix_next;
      o_meta <= s3_meta;
    end
  end

  assign res.valid      = o_v;
  assign res.sharpened  = o_pix;
  assign res.out_row    = o_meta.row;
  assign res.out_col    = o_meta.col;
  assign res.frame_done = o_meta.done;

endmodule

### rtl/laplacian_sharpen_3x3.sv
// Top level of the streaming 3x3 Laplacian sharpening block.
// Takes one 8-bit pixel per clock in raster order while pix_in.ready is high and returns,
// for each interior pixel, (8*centre - neighbours)/3 + centre clamped to 0..255 with its
// row and column, once the pixel below-right of it has arrived. Sustained rate is one
// pixel per clock when the output is not stalled. The pixel that completes a window
// passes in order through the input register with line-store read, window plus kernel
// sum, divide by 3, and clamp into the output register; each stage advances on its
// own, so input can keep flowing into empty stages while a result waits. The two line
// stores share one memory of MAX_WIDTH 16-bit entries, read when a pixel is accepted
// and written one stage later; it needs no clearing pass, as results are emitted only
// from row 2 on, after the frame has written two rows.
// Any write to frame_width or frame_height restarts the frame at row 0, col 0;
// sizes are clamped to 3..MAX_WIDTH and 3..1024. Write configuration only
// while the block is idle.
`include "assert_macros.svh"

module laplacian_sharpen_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic      clk,
  input  logic      rst,
  lsh_pix_if.sink   pix_in,
  lsh_res_if.source res_out,
  lsh_cfg_if.sink   cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WIDTH_RST_USE =
    (lsh_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : lsh_pkg::FRAME_WIDTH_RST;
  localparam logic [CW-1:0] COL_LAST_RST = CW'(WIDTH_RST_USE - 1);
  localparam logic [lsh_pkg::POS_W-1:0] ROW_LAST_RST =
    lsh_pkg::POS_W'(lsh_pkg::FRAME_HEIGHT_RST - 1);

  logic [CW-1:0]             col_count;
  logic [lsh_pkg::POS_W-1:0] row_count;
  logic [CW-1:0]             col_last;
  logic [lsh_pkg::POS_W-1:0] row_last;

  logic [CW:0]                     width_use;
  logic [lsh_pkg::CFG_DATA_W-1:0]  height_use;
  logic                            cfg_fire;
  logic                            cfg_hit;

  logic [2*lsh_pkg::PIX_W-1:0] lines [MAX_WIDTH];
  logic [2*lsh_pkg::PIX_W-1:0] line_rd;

  logic                      in_fire;
  logic                      load;
  logic                      load_ready;
  logic                      s1_v;
  logic [lsh_pkg::PIX_W-1:0] s1_pix;
  logic [CW-1:0]             s1_col;
  lsh_pkg::lsh_meta_t        s1_meta;
  lsh_pkg::lsh_meta_t        meta_next;
  lsh_pkg::lsh_col_t         column;

  // Configuration
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign cfg_hit   = cfg_fire && (cfg.index == lsh_pkg::CFG_FRAME_WIDTH ||
                                  cfg.index == lsh_pkg::CFG_FRAME_HEIGHT);

  always_comb begin
    if (32'(cfg.data) < lsh_pkg::FRAME_MIN) begin
      width_use = (CW+1)'(lsh_pkg::FRAME_MIN);
    end else if (32'(cfg.data) > MAX_WIDTH) begin
      width_use = (CW+1)'(MAX_WIDTH);
    end else begin
      width_use = (CW+1)'(cfg.data);
    end
    if (32'(cfg.data) < lsh_pkg::FRAME_MIN) begin
      height_use = lsh_pkg::CFG_DATA_W'(lsh_pkg::FRAME_MIN);
    end else if (32'(cfg.data) > lsh_pkg::MAX_HEIGHT) begin
      height_use = lsh_pkg::CFG_DATA_W'(lsh_pkg::MAX_HEIGHT);
    end else begin
      height_use = cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= COL_LAST_RST;
      row_last <= ROW_LAST_RST;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        lsh_pkg::CFG_FRAME_WIDTH:  col_last <= CW'(width_use - 1'b1);
        lsh_pkg::CFG_FRAME_HEIGHT: row_last <= lsh_pkg::POS_W'(height_use - 1'b1);
        default: ;
      endcase
    end
  end

  // Raster position of the next pixel
  assign in_fire = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      if (col_count == col_last) begin
        col_count <= '0;
        row_count <= (row_count == row_last) ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_comb begin
    meta_next.emit = (row_count >= lsh_pkg::POS_W'(2)) && (32'(col_count) >= 32'd2);
    meta_next.row  = row_count - 1'b1;
    meta_next.col  = lsh_pkg::POS_W'(32'(col_count) - 32'd1);
    meta_next.done = (row_count == row_last) && (col_count == col_last);
  end

  // Input stage
  assign load          = s1_v && load_ready;
  assign pix_in.ready  = !s1_v || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (pix_in.ready) begin
      s1_v <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix  <= pix_in.pixel;
      s1_col  <= col_count;
      s1_meta <= meta_next;
    end
  end

  // Line stores: upper byte two rows above, lower byte row above
  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_rd <= lines[col_count];
    end
    if (load) begin
      lines[s1_col] <= {line_rd[lsh_pkg::PIX_W-1:0], s1_pix};
    end
  end

  assign column.top = line_rd[2*lsh_pkg::PIX_W-1:lsh_pkg::PIX_W];
  assign column.mid = line_rd[lsh_pkg::PIX_W-1:0];
  assign column.bot = s1_pix;

  lsh_sharpen u_sharpen (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .column     (column),
    .meta       (s1_meta),
    .load_ready (load_ready),
    .res        (res_out)
  );

  `LSH_ASSERT_NOW(a_col_in_range, 1'b1, col_count <= col_last, "column counter past row end")
  `LSH_ASSERT_NEXT(a_cfg_restart, cfg_hit, col_count == '0 && row_count == '0,
                   "register write did not restart the frame")
  `LSH_ASSERT_NEXT(a_frame_wrap, in_fire && col_count == col_last && row_count == row_last,
                   col_count == '0 && row_count == '0, "frame did not wrap after last pixel")
  `LSH_ASSERT_NEXT(a_s1_hold, s1_v && !load_ready,
                   s1_v && $stable(s1_col) && $stable(s1_pix), "stalled input stage lost its pixel")

endmodule
